### hdl/hall_commutation_speed_defines.svh
// Assertion helpers for the hall commutation speed controller RTL.
`ifndef HALL_COMMUTATION_SPEED_DEFINES_SVH
`define HALL_COMMUTATION_SPEED_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HCS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define HCS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/hcs_pkg.sv
package hcs_pkg;

   // Field widths
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned CMP_W   = 16;
   localparam int unsigned RPM_W   = 21;
   localparam int unsigned EN_W    = 6;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [RPM_W-1:0] RPM_MAX = '1;
   localparam logic [CMP_W-1:0] CMP_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_CW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_ENABLE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_REFERENCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_TOP           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_TOP         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL      = 3'd5;

   // Register reset values
   localparam logic [CMP_W-1:0]   PWM_TOP_RST      = 16'd4095;
   localparam logic [COUNT_W-1:0] TIMER_TOP_RST    = 32'hFFFF_FFFF;
   localparam logic [CMP_W-1:0]   MIN_INTERVAL_RST = 16'd500;

   // Phase drive
   typedef enum logic [1:0] {
      DRV_OFF  = 2'd0,
      DRV_HIGH = 2'd1,
      DRV_LOW  = 2'd2
   } drive_type;

   typedef drive_type [2:0] phase_drive_type;   // index 0 = A

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_in;
      logic calc;
      logic mul;
      logic div_start;
      logic rpm_load;
      logic out_load;
   } hcs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic edge_ok;
      logic div_done;
   } hcs_stat_type;

   // Clockwise six-step table; invalid codes leave all phases off
   function automatic phase_drive_type cw_lookup(logic [CODE_W-1:0] code);
      phase_drive_type d;
      d = {DRV_OFF, DRV_OFF, DRV_OFF};
      case (code)
         3'd1: d = {DRV_LOW,  DRV_HIGH, DRV_OFF };
         3'd2: d = {DRV_OFF,  DRV_LOW,  DRV_HIGH};
         3'd3: d = {DRV_LOW,  DRV_OFF,  DRV_HIGH};
         3'd4: d = {DRV_HIGH, DRV_OFF,  DRV_LOW };
         3'd5: d = {DRV_OFF,  DRV_HIGH, DRV_LOW };
         3'd6: d = {DRV_HIGH, DRV_LOW,  DRV_OFF };
         default: d = {DRV_OFF, DRV_OFF, DRV_OFF};
      endcase
      return d;
   endfunction

endpackage

### hdl/hall_commutation_speed.sv
// Channel  Dir  Width  Contents
// req_     in   40     hall_code, timer_count
// rsp_     out  112    commutation, interval, speed; tuser = edge_accepted
// csr_     in   3+32   register index, write data
//
// A request is taken only in idle; csr_ready is always high.
// A rejected edge passes the controller through idle, calc and done; an accepted edge
// adds the multiply state and the bit-serial rpm divider between calc and done.
// A finished response waits in the output register while the next request enters;
// that request then stalls in its done state until the response is taken.
// Synchronous active-high reset restores register defaults and clears state.
module hall_commutation_speed import hcs_pkg::*; #(
   parameter int unsigned EDGES_PER_REV  = 6,
   parameter int unsigned TIMER_CLOCK_HZ = 54000000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] hall_code, [34:3] timer_count
   input  logic [39:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] pwm_on, [6:1] phase_enables, [22:7] compare_a, [38:23] compare_b,
   // [54:39] compare_c, [86:55] interval, [107:87] speed_rpm
   output logic [111:0]          rsp_tdata,
   // [0] edge_accepted
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   hcs_cmd_type        cmd;
   hcs_stat_type       stat;
   logic               pwm_on;
   logic [EN_W-1:0]    phase_enables;
   logic [CMP_W-1:0]   compare_a, compare_b, compare_c;
   logic [COUNT_W-1:0] interval;
   logic               edge_accepted;
   logic [RPM_W-1:0]   speed_rpm;

   assign csr_ready = 1'b1;

   hcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hcs_dpath #(
      .EDGES_PER_REV  (EDGES_PER_REV),
      .TIMER_CLOCK_HZ (TIMER_CLOCK_HZ)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid & csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .hall_code     (req_tdata[2:0]),
      .timer_count   (req_tdata[34:3]),
      .cmd           (cmd),
      .stat          (stat),
      .pwm_on        (pwm_on),
      .phase_enables (phase_enables),
      .compare_a     (compare_a),
      .compare_b     (compare_b),
      .compare_c     (compare_c),
      .interval      (interval),
      .edge_accepted (edge_accepted),
      .speed_rpm     (speed_rpm)
   );

   // Pack the response
   assign rsp_tdata = {4'b0000, speed_rpm, interval, compare_c, compare_b, compare_a,
                       phase_enables, pwm_on};
   assign rsp_tuser = edge_accepted;

endmodule

### hdl/hcs_div.sv
// Restoring divider, one quotient bit per cycle.
module hcs_div import hcs_pkg::*; #(
   parameter int unsigned NUM_W = 34,
   parameter int unsigned DEN_W = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,   // held stable while busy
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;   // numerator shifts out, quotient in

   logic [DEN_W:0]   trial;
   logic             fits;

   // One restoring step
   always_comb begin
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      fits    = (trial >= {1'b0, denom});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = numer;
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_W'(trial - {1'b0, denom}) : trial[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### hdl/hcs_dpath.sv
// Datapath: config registers, commutation, interval, speed and result register.
module hcs_dpath import hcs_pkg::*; #(
   parameter int unsigned EDGES_PER_REV  = 6,
   parameter int unsigned TIMER_CLOCK_HZ = 54000000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [CODE_W-1:0]     hall_code,
   input  logic [COUNT_W-1:0]    timer_count,
   input  hcs_cmd_type           cmd,
   output hcs_stat_type          stat,
   output logic                  pwm_on,
   output logic [EN_W-1:0]       phase_enables,
   output logic [CMP_W-1:0]      compare_a,
   output logic [CMP_W-1:0]      compare_b,
   output logic [CMP_W-1:0]      compare_c,
   output logic [COUNT_W-1:0]    interval,
   output logic                  edge_accepted,
   output logic [RPM_W-1:0]      speed_rpm
);

   localparam longint unsigned NUM_VAL = 64'd60 * 64'(TIMER_CLOCK_HZ);
   localparam int unsigned NUM_W = $clog2(NUM_VAL + 1);
   localparam int unsigned EPR_W = $clog2(EDGES_PER_REV + 1);
   localparam int unsigned DEN_W = COUNT_W + EPR_W;

   // Config registers
   logic               dir_cw_ff, run_en_ff;
   logic [CMP_W-1:0]   vref_ff, pwm_top_ff, min_int_ff;
   logic [COUNT_W-1:0] timer_top_ff;

   // Captured request and state
   logic [CODE_W-1:0]  code_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] last_edge_ff;
   logic [RPM_W-1:0]   rpm_ff, rpm_in;
   logic [CMP_W-1:0]   cmp_ff [3];
   logic [CMP_W-1:0]   cmp_in [3];
   logic [EN_W-1:0]    en_ff, en_in;
   logic [COUNT_W-1:0] delta_ff, delta_in;
   logic               accepted_ff;
   logic [DEN_W-1:0]   den_ff;

   // Result register
   logic               out_pwm_ff;
   logic [EN_W-1:0]    out_en_ff;
   logic [CMP_W-1:0]   out_cmp_a_ff, out_cmp_b_ff, out_cmp_c_ff;
   logic [COUNT_W-1:0] out_delta_ff;
   logic               out_acc_ff;
   logic [RPM_W-1:0]   out_rpm_ff;

   logic [CMP_W-1:0]   high_val, low_val;
   phase_drive_type    cw_drv;
   drive_type          drv;
   logic               edge_ok;
   logic               div_done;
   logic [NUM_W-1:0]   quot;

   // Config writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_cw_ff    <= 1'b1;
         run_en_ff    <= 1'b0;
         vref_ff      <= '0;
         pwm_top_ff   <= PWM_TOP_RST;
         timer_top_ff <= TIMER_TOP_RST;
         min_int_ff   <= MIN_INTERVAL_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DIRECTION_CW:      dir_cw_ff    <= csr_data[0];
            CSR_RUN_ENABLE:        run_en_ff    <= csr_data[0];
            CSR_VOLTAGE_REFERENCE: vref_ff      <= csr_data[CMP_W-1:0];
            CSR_PWM_TOP:           pwm_top_ff   <= csr_data[CMP_W-1:0];
            CSR_TIMER_TOP:         timer_top_ff <= csr_data[COUNT_W-1:0];
            CSR_MIN_INTERVAL:      min_int_ff   <= csr_data[CMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Commutation: per-phase drive and compare values
   always_comb begin
      high_val = (pwm_top_ff >= vref_ff) ? (pwm_top_ff - vref_ff) : '0;
      low_val  = (pwm_top_ff == CMP_MAX) ? CMP_MAX : (pwm_top_ff + 1'b1);
      cw_drv   = cw_lookup(code_ff);
      en_in    = '0;
      drv      = DRV_OFF;
      for (int p = 0; p < 3; p++) begin
         cmp_in[p] = cmp_ff[p];
         drv = cw_drv[p];
         if (!dir_cw_ff) begin
            case (cw_drv[p])
               DRV_HIGH: drv = DRV_LOW;
               DRV_LOW:  drv = DRV_HIGH;
               default:  drv = DRV_OFF;
            endcase
         end
         if (run_en_ff) begin
            if (drv == DRV_HIGH) begin
               cmp_in[p] = high_val;
               en_in[p]  = 1'b1;
            end else if (drv == DRV_LOW) begin
               cmp_in[p]   = low_val;
               en_in[p+3]  = 1'b1;
            end
         end
      end
   end

   // Edge interval with wrap at timer top
   always_comb begin
      if (count_ff >= last_edge_ff) begin
         delta_in = count_ff - last_edge_ff;
      end else begin
         delta_in = (timer_top_ff - last_edge_ff) + count_ff + 1'b1;
      end
      edge_ok = (delta_in > {{(COUNT_W-CMP_W){1'b0}}, min_int_ff});
   end

   // Quotient saturates to the rpm field
   assign rpm_in = (quot > NUM_W'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];

   // Control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         rpm_ff       <= '0;
         for (int p = 0; p < 3; p++) begin
            cmp_ff[p] <= '0;
         end
      end else begin
         if (cmd.calc) begin
            for (int p = 0; p < 3; p++) begin
               cmp_ff[p] <= cmp_in[p];
            end
            if (edge_ok) begin
               last_edge_ff <= count_ff;
            end
         end
         if (cmd.rpm_load) begin
            rpm_ff <= rpm_in;
         end
      end
   end

   // Working payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         code_ff  <= hall_code;
         count_ff <= timer_count;
      end
      if (cmd.calc) begin
         en_ff       <= en_in;
         delta_ff    <= delta_in;
         accepted_ff <= edge_ok;
      end
      if (cmd.mul) begin
         den_ff <= {{EPR_W{1'b0}}, delta_ff} * DEN_W'(EDGES_PER_REV);
      end
      if (cmd.out_load) begin
         out_pwm_ff   <= run_en_ff;
         out_en_ff    <= en_ff;
         out_cmp_a_ff <= cmp_ff[0];
         out_cmp_b_ff <= cmp_ff[1];
         out_cmp_c_ff <= cmp_ff[2];
         out_delta_ff <= delta_ff;
         out_acc_ff   <= accepted_ff;
         out_rpm_ff   <= rpm_ff;
      end
   end

   hcs_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (NUM_W'(NUM_VAL)),
      .denom (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign stat.edge_ok  = edge_ok;
   assign stat.div_done = div_done;

   assign pwm_on        = out_pwm_ff;
   assign phase_enables = out_en_ff;
   assign compare_a     = out_cmp_a_ff;
   assign compare_b     = out_cmp_b_ff;
   assign compare_c     = out_cmp_c_ff;
   assign interval      = out_delta_ff;
   assign edge_accepted = out_acc_ff;
   assign speed_rpm     = out_rpm_ff;

endmodule

### hdl/hcs_ctrl.sv
`include "hall_commutation_speed_defines.svh"

// Controller: sequences one request through calc, then multiply and divide for an accepted edge, then result.
module hcs_ctrl import hcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  hcs_stat_type stat,
   output hcs_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = stat.edge_ok ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd.mul       = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.rpm_load = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the result register to free up
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   `HCS_ASSERT_IMP(a_busy_no_req, state_ff != ST_IDLE, !req_tready, "request taken while busy")
   `HCS_ASSERT_NXT(a_start_to_div, cmd.div_start, state_ff == ST_DIV, "divide not entered")
   `HCS_ASSERT_IMP(a_done_in_div, stat.div_done, state_ff == ST_DIV, "divider done outside divide")
   `HCS_ASSERT_NXT(a_load_valid, cmd.out_load, rsp_tvalid, "loaded result not offered")

endmodule
